FILE: rtl/mlb_pkg.sv
`default_nettype none

package mlb_pkg;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 3;
  localparam int MASK_W  = 8;
  localparam int PCNT_W  = 4;
  localparam int NPORT_W = 5;

  localparam logic [NPORT_W-1:0] MAX_PORTS    = 5'd8;
  localparam logic [PCNT_W-1:0]  PCNT_RESET   = 4'd8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_PORT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC_CMP,
    ST_SRC_UPD,
    ST_DST_CMP,
    ST_DST_OUT
  } mlb_state_t;

  typedef struct packed {
    logic compare;
    logic insert;
    logic move;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/mlb_if.sv
`default_nettype none

interface mlb_hdr_if import mlb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MAC_W-1:0]  source_mac;
  logic [MAC_W-1:0]  dest_mac;
  logic [PORT_W-1:0] ingress_port;

  modport source (output valid, output source_mac, output dest_mac, output ingress_port,
                  input ready);
  modport sink (input valid, input source_mac, input dest_mac, input ingress_port,
                output ready);
endinterface

interface mlb_dec_if import mlb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] egress_mask;
  logic              dest_known;
  logic              source_learned;
  logic              source_moved;
  logic              learn_dropped;

  modport source (output valid, output egress_mask, output dest_known,
                  output source_learned, output source_moved, output learn_dropped,
                  input ready);
  modport sink (input valid, input egress_mask, input dest_known,
                input source_learned, input source_moved, input learn_dropped,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/mac_learning_bridge_forwarder.sv
// After ST_SRC_CMP, ST_SRC_UPD and ST_DST_CMP, ST_DST_OUT loads the result into the
// output register once it is free. Each request makes a compare pass over the
// cell row for the source, an update, and a second compare pass for the destination.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) empties the table at once and sets port_count to 8.
`default_nettype none

module mac_learning_bridge_forwarder import mlb_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  mlb_hdr_if.sink                hdr,
  mlb_dec_if.source              dec
);

  mlb_state_t        state, state_next;
  logic [PCNT_W-1:0] port_count;
  logic [MAC_W-1:0]  src_mac, dst_mac;
  logic [PORT_W-1:0] ingress;
  logic              learned, moved, dropped;
  cell_ctrl_t        ctrl;
  logic [MAC_W-1:0]  key;
  logic              hit_any, full;
  logic [PORT_W-1:0] hit_port;
  logic              accept, out_free, load_out, do_insert, do_move;
  logic [NPORT_W-1:0] n_ports;
  logic [MASK_W-1:0] use_mask, ingress_bit, mask_next;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PORT_COUNT) ?
                  {{(APB_DW-PCNT_W){1'b0}}, port_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= PCNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PORT_COUNT)) begin
      port_count <= pwdata[PCNT_W-1:0];
    end
  end

  assign accept   = hdr.valid && hdr.ready;
  assign out_free = !dec.valid || dec.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_SRC_CMP;
      ST_SRC_CMP: state_next = ST_SRC_UPD;
      ST_SRC_UPD: state_next = ST_DST_CMP;
      ST_DST_CMP: state_next = ST_DST_OUT;
      ST_DST_OUT: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl      = '0;
    hdr.ready = 1'b0;
    load_out  = 1'b0;
    do_insert = 1'b0;
    do_move   = 1'b0;
    key       = src_mac;
    unique case (state)
      ST_IDLE:    hdr.ready = 1'b1;
      ST_SRC_CMP: ctrl.compare = 1'b1;
      ST_SRC_UPD: begin
        do_insert   = !hit_any && !full;
        do_move     = hit_any && (hit_port != ingress);
        ctrl.insert = do_insert;
        ctrl.move   = do_move;
      end
      ST_DST_CMP: begin
        ctrl.compare = 1'b1;
        key          = dst_mac;
      end
      ST_DST_OUT: load_out = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_mac <= hdr.source_mac;
      dst_mac <= hdr.dest_mac;
      ingress <= hdr.ingress_port;
    end
    if (state == ST_SRC_UPD) begin
      learned <= do_insert;
      moved   <= do_move;
      dropped <= !hit_any && full;
    end
  end

  mlb_chain #(
    .DEPTH (TABLE_DEPTH)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .key      (key),
    .ingress  (ingress),
    .hit_any  (hit_any),
    .hit_port (hit_port),
    .full     (full)
  );

  always_comb begin
    if (port_count == '0) begin
      n_ports = NPORT_W'(1);
    end else if ({1'b0, port_count} > MAX_PORTS) begin
      n_ports = MAX_PORTS;
    end else begin
      n_ports = {1'b0, port_count};
    end
    for (int p = 0; p < MASK_W; p++) begin
      use_mask[p] = (NPORT_W'(p) < n_ports);
    end
    ingress_bit = MASK_W'(1) << ingress;
    if (!hit_any) begin
      mask_next = use_mask & ~ingress_bit;
    end else if (hit_port != ingress) begin
      mask_next = (MASK_W'(1) << hit_port) & use_mask;
    end else begin
      mask_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else if (load_out) begin
      dec.valid <= 1'b1;
    end else if (dec.ready) begin
      dec.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      dec.egress_mask    <= mask_next;
      dec.dest_known     <= hit_any;
      dec.source_learned <= learned;
      dec.source_moved   <= moved;
      dec.learn_dropped  <= dropped;
    end
  end

`ifndef SYNTH
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DST_OUT) |-> $onehot0({learned, moved, dropped}))
    else $error("more than one learning flag set");

  a_accept_starts_compare: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SRC_CMP))
    else $error("accepted request did not start the source compare");

  a_flood_skips_ingress: assert property (@(posedge clk) disable iff (rst)
    (load_out && !hit_any) |-> !mask_next[ingress])
    else $error("flood mask includes the ingress port");

  a_insert_only_when_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |-> (!full && !hit_any && (state == ST_SRC_UPD)))
    else $error("insert into a full table or for a known source");
`endif

endmodule

`default_nettype wire

FILE: rtl/mlb_cell.sv
`default_nettype none

module mlb_cell import mlb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [MAC_W-1:0]  key,
  input  wire logic [PORT_W-1:0] ingress,
  input  wire logic              prev_valid,
  input  wire logic [MAC_W-1:0]  prev_mac,
  input  wire logic [PORT_W-1:0] prev_port,
  output logic                   valid,
  output logic [MAC_W-1:0]       mac,
  output logic [PORT_W-1:0]      port,
  output logic                   hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        hit <= valid && (mac == key);
      end
      if (ctrl.insert) begin
        valid <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      mac  <= prev_mac;
      port <= prev_port;
    end else if (ctrl.move && hit) begin
      port <= ingress;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mlb_chain.sv
`default_nettype none

module mlb_chain import mlb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [MAC_W-1:0]  key,
  input  wire logic [PORT_W-1:0] ingress,
  output logic                   hit_any,
  output logic [PORT_W-1:0]      hit_port,
  output logic                   full
);

  logic              valid_c [DEPTH+1];
  logic [MAC_W-1:0]  mac_c   [DEPTH+1];
  logic [PORT_W-1:0] port_c  [DEPTH+1];
  logic [DEPTH-1:0]  hits;
  logic [DEPTH-1:0]  port_col [PORT_W];

  // A new entry enters at the head of the row and every entry moves one cell on.
  assign valid_c[0] = 1'b1;
  assign mac_c[0]   = key;
  assign port_c[0]  = ingress;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    mlb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (key),
      .ingress    (ingress),
      .prev_valid (valid_c[k]),
      .prev_mac   (mac_c[k]),
      .prev_port  (port_c[k]),
      .valid      (valid_c[k+1]),
      .mac        (mac_c[k+1]),
      .port       (port_c[k+1]),
      .hit        (hits[k])
    );
    for (genvar b = 0; b < PORT_W; b++) begin : g_col
      assign port_col[b][k] = hits[k] & port_c[k+1][b];
    end
  end

  // Addresses in the row are unique, so at most one cell hits.
  for (genvar b = 0; b < PORT_W; b++) begin : g_port
    assign hit_port[b] = |port_col[b];
  end

  assign hit_any = |hits;
  assign full    = valid_c[DEPTH];

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench import mlb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STATION_SLOTS = 64;
  localparam int MAC_POOL = 80;
  localparam int PHASE_FRAMES = 125;
  localparam int REG_UNUSED = 1;
  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;

  typedef struct packed {
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  dest_mac;
    logic [PORT_W-1:0] ingress_port;
  } header_t;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              dest_known;
    logic              source_learned;
    logic              source_moved;
    logic              learn_dropped;
  } decision_t;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          reg_index;
    logic [31:0] reg_value;
    header_t     frame;
    logic        typed;
    decision_t   want;
  } step_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mlb_hdr_if hdr_ch ();
  mlb_dec_if dec_ch ();

  mac_learning_bridge_forwarder #(.TABLE_DEPTH(STATION_SLOTS)) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr     (hdr_ch),
    .dec     (dec_ch)
  );

  // Shadow of the forwarding table and the port count register.
  logic [PCNT_W-1:0] port_count_cfg;
  logic [MAC_W-1:0]  station_mac [STATION_SLOTS];
  logic [PORT_W-1:0] station_port [STATION_SLOTS];
  int                station_count;

  decision_t         pending_decisions [$];
  int                bad_decisions;
  logic              hold_output;
  logic              steady;
  logic [MAC_W-1:0]  known_macs [MAC_POOL];
  step_row_t         directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic int ports_in_use();
    int n;
    n = port_count_cfg;
    if (n < 1) n = 1;
    if (n > int'(MAX_PORTS)) n = int'(MAX_PORTS);
    return n;
  endfunction

  function automatic int find_station(logic [MAC_W-1:0] mac);
    for (int k = 0; k < station_count; k++) begin
      if (station_mac[k] == mac) return k;
    end
    return -1;
  endfunction

  function automatic decision_t forward_decision(header_t h);
    decision_t         d;
    int                src_slot;
    int                dst_slot;
    logic [MASK_W-1:0] in_use;
    in_use = MASK_W'((1 << ports_in_use()) - 1);
    d = '0;
    src_slot = find_station(h.source_mac);
    if (src_slot < 0) begin
      if (station_count < STATION_SLOTS) begin
        station_mac[station_count] = h.source_mac;
        station_port[station_count] = h.ingress_port;
        station_count++;
        d.source_learned = 1'b1;
      end else begin
        d.learn_dropped = 1'b1;
      end
    end else if (station_port[src_slot] != h.ingress_port) begin
      station_port[src_slot] = h.ingress_port;
      d.source_moved = 1'b1;
    end
    dst_slot = find_station(h.dest_mac);
    if (dst_slot < 0) begin
      d.egress_mask = in_use & ~(MASK_W'(1) << h.ingress_port);
    end else begin
      d.dest_known = 1'b1;
      if (station_port[dst_slot] != h.ingress_port) begin
        d.egress_mask = (MASK_W'(1) << station_port[dst_slot]) & in_use;
      end
    end
    return d;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic logic [MAC_W-1:0] pick_station();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return known_macs[$urandom_range(0, MAC_POOL - 1)];
    if (r < 92) return {16'($urandom), 32'($urandom)};
    r = $urandom_range(0, 2);
    if (r == 0) return MAC_ZERO;
    if (r == 1) return MAC_ONES;
    return MAC_W'(1) << $urandom_range(0, MAC_W - 1);
  endfunction

  function automatic header_t random_header();
    header_t h;
    h.source_mac = pick_station();
    h.dest_mac = ($urandom_range(0, 9) == 0) ? h.source_mac : pick_station();
    if ($urandom_range(0, 99) < 85) begin
      h.ingress_port = PORT_W'($urandom_range(0, ports_in_use() - 1));
    end else begin
      h.ingress_port = PORT_W'($urandom_range(0, 7));
    end
    return h;
  endfunction

  function automatic void add_frame(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                    logic [PORT_W-1:0] ingress);
    step_row_t row;
    row.kind = ROW_FRAME;
    row.reg_index = 0;
    row.reg_value = '0;
    row.frame = '{src, dst, ingress};
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  // Flags are given as {dest_known, source_learned, source_moved, learn_dropped}.
  function automatic void add_checked(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                      logic [PORT_W-1:0] ingress,
                                      logic [MASK_W-1:0] mask, logic [3:0] flags);
    add_frame(src, dst, ingress);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].want = {mask, flags};
  endfunction

  function automatic void add_write(int index, logic [31:0] value);
    step_row_t row;
    row.kind = ROW_WRITE;
    row.reg_index = index;
    row.reg_value = value;
    row.frame = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic send_header(input header_t h, input logic typed, input decision_t want);
    int        gap;
    decision_t d;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      hdr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hdr_ch.valid <= 1'b1;
    hdr_ch.source_mac <= h.source_mac;
    hdr_ch.dest_mac <= h.dest_mac;
    hdr_ch.ingress_port <= h.ingress_port;
    @(posedge clk);
    while (!hdr_ch.ready) @(posedge clk);
    d = forward_decision(h);
    if (typed) d = want;
    pending_decisions.push_back(d);
  endtask

  task automatic wait_drained();
    hdr_ch.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input int index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(index * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == int'(REG_PORT_COUNT)) port_count_cfg = value[PCNT_W-1:0];
  endtask

  always @(posedge clk) begin : check_decisions
    decision_t got;
    decision_t want;
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      got = {dec_ch.egress_mask, dec_ch.dest_known, dec_ch.source_learned,
             dec_ch.source_moved, dec_ch.learn_dropped};
      if (pending_decisions.size() == 0) begin
        if (bad_decisions < 10) $display("unexpected decision %h", got);
        bad_decisions++;
      end else begin
        want = pending_decisions.pop_front();
        if (got != want) begin
          if (bad_decisions < 10) begin
            $display(
              "mismatch: mask %h/%h known %b/%b learned %b/%b moved %b/%b dropped %b/%b",
              want.egress_mask, got.egress_mask, want.dest_known, got.dest_known,
              want.source_learned, got.source_learned, want.source_moved,
              got.source_moved, want.learn_dropped, got.learn_dropped);
          end
          bad_decisions++;
        end
      end
    end
  end

  initial begin : drain_decisions
    int stall;
    dec_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_output) begin
        dec_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
      end
      stall = idle_gap();
      if (stall > 0) begin
        dec_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dec_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [PCNT_W-1:0] phase_ports [8];
    header_t           h;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hdr_ch.valid <= 1'b0;
    hdr_ch.source_mac <= '0;
    hdr_ch.dest_mac <= '0;
    hdr_ch.ingress_port <= '0;
    port_count_cfg = PCNT_RESET;
    station_count = 0;
    bad_decisions = 0;
    hold_output = 1'b0;
    steady = 1'b0;
    phase_ports = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd6, 4'd2, 4'd8};
    foreach (known_macs[k]) known_macs[k] = {16'($urandom), 32'($urandom)};

    add_checked(MAC_ZERO, MAC_ONES, 3'd0, 8'hFE, 4'b0100);
    add_checked(MAC_ONES, MAC_ZERO, 3'd7, 8'h01, 4'b1100);
    add_checked(MAC_ZERO, MAC_ONES, 3'd3, 8'h80, 4'b1010);
    add_checked(MAC_ZERO, MAC_ZERO, 3'd3, 8'h00, 4'b1000);
    add_checked(48'h5555_5555_5555, 48'h5555_5555_5555, 3'd5, 8'h00, 4'b1100);
    add_checked(48'hAAAA_AAAA_AAAA, 48'h0123_4567_89AB, 3'd2, 8'hFB, 4'b0100);
    add_checked(48'h8000_0000_0001, 48'h5555_5555_5555, 3'd2, 8'h20, 4'b1100);
    add_checked(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 3'd5, 8'h04, 4'b1000);
    add_write(int'(REG_PORT_COUNT), 32'd3);
    add_checked(48'h0000_0000_0001, MAC_ONES, 3'd1, 8'h00, 4'b1100);
    add_checked(48'h0000_0000_0002, 48'h0000_0000_0003, 3'd6, 8'h07, 4'b0100);
    add_checked(MAC_ZERO, 48'h5555_5555_5555, 3'd6, 8'h00, 4'b1010);
    add_write(int'(REG_PORT_COUNT), 32'd0);
    add_checked(48'h0000_0000_0004, 48'h0000_0000_0005, 3'd0, 8'h00, 4'b0100);
    add_checked(48'h0000_0000_0006, 48'h0000_0000_0007, 3'd3, 8'h01, 4'b0100);
    add_write(int'(REG_PORT_COUNT), 32'd15);
    add_checked(48'h0000_0000_0008, 48'h0000_0000_0009, 3'd4, 8'hEF, 4'b0100);
    add_write(REG_UNUSED, 32'd2);
    add_checked(48'h0000_0000_000A, 48'h0000_0000_000B, 3'd0, 8'hFE, 4'b0100);
    add_checked(48'hFFFF_0000_FFFF, MAC_ZERO, 3'd7, 8'h40, 4'b1100);
    add_write(int'(REG_PORT_COUNT), 32'hFFFF_FFF2);
    add_checked(48'h0000_0000_0001, 48'h0000_0000_0002, 3'd0, 8'h00, 4'b1010);
    add_frame(48'h0000_0000_0002, 48'h0000_0000_0001, 3'd1);
    add_write(int'(REG_PORT_COUNT), 32'd8);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_drained();
        apb_write(directed_rows[r].reg_index, directed_rows[r].reg_value);
      end else begin
        send_header(directed_rows[r].frame, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    foreach (phase_ports[p]) begin
      wait_drained();
      apb_write(int'(REG_PORT_COUNT), {28'($urandom), phase_ports[p]});
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 4) == 0);
        if (p == 2 && i == 40) hold_output = 1'b1;
        h = random_header();
        send_header(h, 1'b0, '0);
      end
    end

    wait_drained();
    if (bad_decisions == 0 && pending_decisions.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/mlb_pkg.sv
rtl/mlb_if.sv
rtl/mlb_cell.sv
rtl/mlb_chain.sv
rtl/mac_learning_bridge_forwarder.sv
tb/testbench.sv
